### hdl/vn_pkg.sv
// vn_pkg: shared widths and data types for the vector normalizer pipeline.
// No dependencies; used by every module under hdl/.
package vn_pkg;

  localparam int CW   = 32;                    // input component width
  localparam int OFB  = 30;                    // output fraction bits
  localparam int OW   = OFB + 2;               // output component width
  localparam int SW   = 2 * CW + 2;            // sum of squares width
  localparam int W    = 2 * CW + 2 * OFB + 4;  // remainder / partial product width
  localparam int NCELL = OFB + 1;              // one cell per quotient bit
  localparam int BW   = $clog2(NCELL);         // bit index width

  typedef struct packed {
    logic [W-1:0]   r;    // m^2 * 2^(2*OFB) - q^2 * S
    logic [W-1:0]   p;    // q * S
    logic [OFB:0]   q;    // quotient magnitude so far
    logic           neg;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]    lane;
    logic  [W-1:0]  s;    // sum of squares
    logic           zero;
  } cell_t;

endpackage

### hdl/vn_prep.sv
// vn_prep: magnitudes, squares and sum of squares; seeds the cell row.
// Depends on vn_pkg.
module vn_prep (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic signed [vn_pkg::CW-1:0] x_i,
  input  logic signed [vn_pkg::CW-1:0] y_i,
  input  logic signed [vn_pkg::CW-1:0] z_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output vn_pkg::cell_t            data_o
);

  logic [vn_pkg::CW-1:0]   mag_d [3];
  logic [vn_pkg::CW-1:0]   mag_q [3];
  logic [2:0]              neg_d, neg_q, neg2_q;
  logic [2*vn_pkg::CW-1:0] sq_d [3];
  logic [2*vn_pkg::CW-1:0] sq_q [3];
  logic                    v1_q, v2_q, v3_q;
  logic                    rdy1, rdy2, rdy3;
  logic [vn_pkg::SW-1:0]   sum;
  vn_pkg::cell_t           seed_d, seed_q;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v3_q;
  assign data_o  = seed_q;

  always_comb begin
    neg_d = {z_i[vn_pkg::CW-1], y_i[vn_pkg::CW-1], x_i[vn_pkg::CW-1]};
    mag_d[0] = neg_d[0] ? (~x_i + 1'b1) : x_i;
    mag_d[1] = neg_d[1] ? (~y_i + 1'b1) : y_i;
    mag_d[2] = neg_d[2] ? (~z_i + 1'b1) : z_i;
    for (int k = 0; k < 3; k++) begin
      sq_d[k] = {{vn_pkg::CW{1'b0}}, mag_q[k]} * {{vn_pkg::CW{1'b0}}, mag_q[k]};
    end
  end

  always_comb begin
    sum = {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
    seed_d.s    = {{(vn_pkg::W-vn_pkg::SW){1'b0}}, sum};
    seed_d.zero = (sum == '0);
    for (int k = 0; k < 3; k++) begin
      seed_d.lane[k].r   = {{(vn_pkg::W-2*vn_pkg::CW){1'b0}}, sq_q[k]} << (2 * vn_pkg::OFB);
      seed_d.lane[k].p   = '0;
      seed_d.lane[k].q   = '0;
      seed_d.lane[k].neg = neg2_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
    end
    if (rdy2 && v1_q) begin
      sq_q   <= sq_d;
      neg2_q <= neg_q;
    end
    if (rdy3 && v2_q) begin
      seed_q <= seed_d;
    end
  end

endmodule

### hdl/vn_cell.sv
// vn_cell: decides one quotient bit for all three lanes, shift-and-add only.
// Depends on vn_pkg.
module vn_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [vn_pkg::BW-1:0] bit_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  vn_pkg::cell_t        data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output vn_pkg::cell_t        data_o
);

  logic [vn_pkg::W:0] d [3];
  logic [2:0]         fit;
  vn_pkg::cell_t      data_d, data_q;
  logic               valid_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Setting bit b adds (2*q*2^b + 2^2b) * S to q^2 * S.
  always_comb begin
    data_d = data_i;
    for (int k = 0; k < 3; k++) begin
      d[k] = ({1'b0, data_i.lane[k].p} << (bit_i + 1)) + ({1'b0, data_i.s} << (2 * bit_i));
      fit[k] = (d[k] <= {1'b0, data_i.lane[k].r});
      if (fit[k]) begin
        data_d.lane[k].r = data_i.lane[k].r - d[k][vn_pkg::W-1:0];
        data_d.lane[k].p = data_i.lane[k].p + (data_i.s << bit_i);
        data_d.lane[k].q[bit_i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

### hdl/vector3_normalize.sv
// Normalizes a signed 3D vector to a Q2.30 unit vector, truncated toward zero.
// One vector is taken per cycle unless stalled; it passes three setup stages
// (magnitude, squares, sum), a row of 31 cells that each resolve one quotient
// bit for all three components with a shift, add and compare, and an output
// register. An all-zero vector gives zero components with zero_length_o set.
// Stalls collapse bubbles stage by stage. Depends on vn_pkg, vn_prep, vn_cell.
module vector3_normalize (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [vn_pkg::CW-1:0] x_in_i,
  input  logic signed [vn_pkg::CW-1:0] y_in_i,
  input  logic signed [vn_pkg::CW-1:0] z_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [vn_pkg::OW-1:0] x_unit_o,
  output logic signed [vn_pkg::OW-1:0] y_unit_o,
  output logic signed [vn_pkg::OW-1:0] z_unit_o,
  output logic                         zero_length_o
);

  vn_pkg::cell_t             chain_data [vn_pkg::NCELL+1];
  logic [vn_pkg::NCELL:0]    chain_valid;
  logic [vn_pkg::NCELL:0]    chain_ready;
  logic                      out_valid_q, out_rdy;
  logic [vn_pkg::OW-1:0]     unit_d [3];
  logic [vn_pkg::OW-1:0]     unit_q [3];
  logic                      zero_q;

  vn_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .x_i     (x_in_i),
    .y_i     (y_in_i),
    .z_i     (z_in_i),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .data_o  (chain_data[0])
  );

  for (genvar i = 0; i < vn_pkg::NCELL; i++) begin : g_cell
    vn_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bit_i   (vn_pkg::BW'(vn_pkg::OFB - i)),
      .valid_i (chain_valid[i]),
      .ready_o (chain_ready[i]),
      .data_i  (chain_data[i]),
      .valid_o (chain_valid[i+1]),
      .ready_i (chain_ready[i+1]),
      .data_o  (chain_data[i+1])
    );
  end

  assign out_rdy = !out_valid_q || out_ready_i;
  assign chain_ready[vn_pkg::NCELL] = out_rdy;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (chain_data[vn_pkg::NCELL].zero) begin
        unit_d[k] = '0;
      end else if (chain_data[vn_pkg::NCELL].lane[k].neg) begin
        unit_d[k] = '0 - {1'b0, chain_data[vn_pkg::NCELL].lane[k].q};
      end else begin
        unit_d[k] = {1'b0, chain_data[vn_pkg::NCELL].lane[k].q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_rdy) begin
      out_valid_q <= chain_valid[vn_pkg::NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && chain_valid[vn_pkg::NCELL]) begin
      unit_q <= unit_d;
      zero_q <= chain_data[vn_pkg::NCELL].zero;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign x_unit_o      = unit_q[0];
  assign y_unit_o      = unit_q[1];
  assign z_unit_o      = unit_q[2];
  assign zero_length_o = zero_q;

endmodule

### hdl/vn_checker.sv
// vn_checker: port-level assertions for vector3_normalize, bound to the top.
// Depends on vn_pkg.
module vn_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic signed [vn_pkg::OW-1:0] x_unit_o,
  input logic signed [vn_pkg::OW-1:0] y_unit_o,
  input logic signed [vn_pkg::OW-1:0] z_unit_o,
  input logic                         zero_length_o
);

  localparam logic signed [vn_pkg::OW-1:0] One = vn_pkg::OW'(1) << vn_pkg::OFB;

  // stalled transfer holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(x_unit_o)
      && $stable(y_unit_o) && $stable(z_unit_o) && $stable(zero_length_o))
    else $error("output changed while stalled");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_length_o |-> x_unit_o == '0 && y_unit_o == '0 && z_unit_o == '0)
    else $error("zero vector gave nonzero components");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> x_unit_o <= One && x_unit_o >= -One && y_unit_o <= One
      && y_unit_o >= -One && z_unit_o <= One && z_unit_o >= -One)
    else $error("unit component out of range");

  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !zero_length_o |-> x_unit_o != '0 || y_unit_o != '0 || z_unit_o != '0)
    else $error("nonzero vector gave all-zero result");

endmodule

bind vector3_normalize vn_checker u_vn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .x_unit_o      (x_unit_o),
  .y_unit_o      (y_unit_o),
  .z_unit_o      (z_unit_o),
  .zero_length_o (zero_length_o)
);
